[rtl/rbsi_pkg.sv]
// Shared types and constants for the ray/box slab intersection block.
`default_nettype none
package rbsi_pkg;

  // Signed fixed-point coordinate and distance
  typedef logic signed [31:0] fix_t;
  // Difference of two coordinates, one bit wider
  typedef logic signed [32:0] diff_t;

  localparam fix_t TMax  = 32'sh7FFF_FFFF;
  localparam fix_t TMin  = 32'sh8000_0000;
  localparam fix_t TZero = 32'sh0000_0000;

  localparam int unsigned NumAxes = 3;
  localparam int unsigned ThrW    = 16;

  // Per-axis flags decided before the divisions
  typedef struct packed {
    logic par;      // direction counts as parallel
    logic in_slab;  // origin lies within the slab
  } axis_flags_t;

  typedef axis_flags_t [NumAxes-1:0] flags_t;

endpackage
`default_nettype wire

[rtl/rbsi_if.sv]
// Valid/ready channel interfaces for ray items and hit result items.
`default_nettype none
interface rbsi_ray_if;
  import rbsi_pkg::*;
  logic valid;
  logic ready;
  fix_t origin_x;
  fix_t origin_y;
  fix_t origin_z;
  fix_t dir_x;
  fix_t dir_y;
  fix_t dir_z;
  fix_t box_min_x;
  fix_t box_min_y;
  fix_t box_min_z;
  fix_t box_max_x;
  fix_t box_max_y;
  fix_t box_max_z;

  modport source (
    output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
           box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    input  ready
  );
  modport sink (
    input  valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
           box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    output ready
  );
endinterface

interface rbsi_hit_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [30:0] entry_distance;

  modport source (output valid, hit, entry_distance, input ready);
  modport sink (input valid, hit, entry_distance, output ready);
endinterface
`default_nettype wire

[rtl/rbsi_prep.sv]
// Front stage: slab differences and parallel/inside flags per axis.
`default_nettype none
module rbsi_prep (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              en_i,
  input  wire logic                              valid_i,
  input  wire logic [rbsi_pkg::ThrW-1:0]         thr_i,
  input  wire rbsi_pkg::fix_t [2:0]              org_i,
  input  wire rbsi_pkg::fix_t [2:0]              dir_i,
  input  wire rbsi_pkg::fix_t [2:0]              lo_i,
  input  wire rbsi_pkg::fix_t [2:0]              hi_i,
  output logic                                   valid_o,
  output rbsi_pkg::diff_t [2:0]                  dlo_o,
  output rbsi_pkg::diff_t [2:0]                  dhi_o,
  output rbsi_pkg::fix_t [2:0]                   dir_o,
  output rbsi_pkg::flags_t                       flags_o
);
  import rbsi_pkg::*;

  logic             valid_q;
  diff_t [2:0]      dlo_d, dlo_q, dhi_d, dhi_q;
  fix_t  [2:0]      dir_q;
  flags_t           flags_d, flags_q;
  logic  [2:0][31:0] mag;

  // Form differences, direction magnitude and the flags
  always_comb begin
    for (int a = 0; a < NumAxes; a++) begin
      dlo_d[a] = diff_t'(lo_i[a]) - diff_t'(org_i[a]);
      dhi_d[a] = diff_t'(hi_i[a]) - diff_t'(org_i[a]);
      mag[a]   = dir_i[a][31] ? (32'd0 - dir_i[a]) : dir_i[a];
      flags_d[a].par     = (mag[a] <= {{(32-ThrW){1'b0}}, thr_i});
      flags_d[a].in_slab = (org_i[a] >= lo_i[a]) && (org_i[a] <= hi_i[a]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dlo_q   <= dlo_d;
      dhi_q   <= dhi_d;
      dir_q   <= dir_i;
      flags_q <= flags_d;
    end
  end

  assign valid_o = valid_q;
  assign dlo_o   = dlo_q;
  assign dhi_o   = dhi_q;
  assign dir_o   = dir_q;
  assign flags_o = flags_q;

endmodule
`default_nettype wire

[rtl/rbsi_divider.sv]
// Pipelined restoring divider, one quotient bit per stage, saturating.
`default_nettype none
module rbsi_divider #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            valid_i,
  input  wire rbsi_pkg::diff_t num_i,
  input  wire rbsi_pkg::fix_t  den_i,
  output logic                 valid_o,
  output rbsi_pkg::fix_t       quo_o
);
  import rbsi_pkg::*;

  // Scaled numerator magnitude width
  localparam int unsigned NW = 33 + FRAC_BITS;

  logic              v_q   [NW+1];
  logic [NW-1:0]     n_q   [NW+1];
  logic [31:0]       d_q   [NW+1];
  logic [31:0]       r_q   [NW+1];
  logic [31:0]       qt_q  [NW+1];
  logic              ovf_q [NW+1];
  logic              neg_q [NW+1];
  logic              out_v_q;
  fix_t              quo_d, quo_q;
  logic [32:0]       nmag;

  // Take magnitudes and the quotient sign
  assign nmag = num_i[32] ? (33'd0 - num_i) : num_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q[0]   <= {nmag, {FRAC_BITS{1'b0}}};
      d_q[0]   <= den_i[31] ? (32'd0 - den_i) : den_i;
      r_q[0]   <= '0;
      qt_q[0]  <= '0;
      ovf_q[0] <= 1'b0;
      neg_q[0] <= num_i[32] ^ den_i[31];
    end
  end

  // One quotient bit per stage
  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [32:0] trial;
    logic        ge;
    logic [32:0] diff;

    assign trial = {r_q[k], n_q[k][NW-1]};
    assign ge    = (trial >= {1'b0, d_q[k]});
    assign diff  = trial - {1'b0, d_q[k]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[k+1]   <= {n_q[k][NW-2:0], 1'b0};
        d_q[k+1]   <= d_q[k];
        r_q[k+1]   <= ge ? diff[31:0] : trial[31:0];
        qt_q[k+1]  <= {qt_q[k][30:0], ge};
        ovf_q[k+1] <= ovf_q[k] | qt_q[k][31];
        neg_q[k+1] <= neg_q[k];
      end
    end
  end

  // Apply the sign and saturate to the signed range
  always_comb begin
    if (neg_q[NW]) begin
      if (ovf_q[NW] || (qt_q[NW] > 32'h8000_0000)) begin
        quo_d = TMin;
      end else begin
        quo_d = fix_t'(32'd0 - qt_q[NW]);
      end
    end else begin
      if (ovf_q[NW] || qt_q[NW][31]) begin
        quo_d = TMax;
      end else begin
        quo_d = fix_t'(qt_q[NW]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en_i) begin
      out_v_q <= v_q[NW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quo_q <= quo_d;
    end
  end

  assign valid_o = out_v_q;
  assign quo_o   = quo_q;

endmodule
`default_nettype wire

[rtl/rbsi_combine.sv]
// Back stages: order slab distances, narrow the interval, decide the hit.
`default_nettype none
module rbsi_combine (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire logic                 valid_i,
  input  wire rbsi_pkg::fix_t [2:0] qlo_i,
  input  wire rbsi_pkg::fix_t [2:0] qhi_i,
  input  wire rbsi_pkg::flags_t     flags_i,
  output logic                      valid_o,
  output logic                      hit_o,
  output logic [30:0]               dist_o
);
  import rbsi_pkg::*;

  logic        v1_q, v2_q, v3_q, v4_q;
  fix_t [2:0]  a_d, a_q, b_d, b_q;
  logic        ok_d, ok1_q, ok2_q, ok3_q;
  fix_t        l2_q, u2_q, az_q, bz_q;
  fix_t        l3_d, l3_q, u3_q;
  logic        hit_q;
  logic [30:0] dist_q;

  // Order each axis pair; parallel axes leave the interval alone
  always_comb begin
    ok_d = 1'b1;
    for (int a = 0; a < NumAxes; a++) begin
      if (flags_i[a].par) begin
        a_d[a] = TZero;
        b_d[a] = TMax;
        ok_d   = ok_d & flags_i[a].in_slab;
      end else if (qlo_i[a] > qhi_i[a]) begin
        a_d[a] = qhi_i[a];
        b_d[a] = qlo_i[a];
      end else begin
        a_d[a] = qlo_i[a];
        b_d[a] = qhi_i[a];
      end
    end
  end

  // Clamp lower bound at zero after the last axis
  always_comb begin
    l3_d = (l2_q > az_q) ? l2_q : az_q;
    if (l3_d < TZero) begin
      l3_d = TZero;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q    <= a_d;
      b_q    <= b_d;
      ok1_q  <= ok_d;
      l2_q   <= (a_q[0] > a_q[1]) ? a_q[0] : a_q[1];
      u2_q   <= (b_q[0] < b_q[1]) ? b_q[0] : b_q[1];
      az_q   <= a_q[2];
      bz_q   <= b_q[2];
      ok2_q  <= ok1_q;
      l3_q   <= l3_d;
      u3_q   <= (u2_q < bz_q) ? u2_q : bz_q;
      ok3_q  <= ok2_q;
      hit_q  <= ok3_q && (l3_q <= u3_q);
      dist_q <= (ok3_q && (l3_q <= u3_q)) ? l3_q[30:0] : 31'd0;
    end
  end

  assign valid_o = v4_q;
  assign hit_o   = hit_q;
  assign dist_o  = dist_q;

endmodule
`default_nettype wire

[rtl/ray_box_slab_intersect.sv]
// Top level: ray/axis-aligned box slab test, one item per cycle unless stalled.
//
// Usage:
//   ray_i   carries one ray (origin, direction) and one box (lower and upper
//           corner) per item, signed fixed point with FRAC_BITS fraction bits.
//   hit_o   carries one result item per ray item, in order: hit flag and the
//           entry distance (0 when the origin is inside the box, 0 on a miss).
//   cfg_we_i/cfg_wdata_i write the parallel threshold; write only while idle.
// Throughput: one item per cycle unless stalled. Path: each item passes the
//   prep register, the six pipelined dividers that resolve one quotient bit
//   per stage, and the combine stages.
// Reset: the pipeline empties and the threshold returns to 1.
// Stall: every stage holds, empty ones too, and the input is refused while a
//   result waits and the receiver is not ready. Nothing is dropped or
//   repeated.
`default_nettype none
module ray_box_slab_intersect #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [rbsi_pkg::ThrW-1:0]    cfg_wdata_i,
  rbsi_ray_if.sink                          ray_i,
  rbsi_hit_if.source                        hit_o
);
  import rbsi_pkg::*;

  // Divider latency, carried by the flag delay line
  localparam int unsigned DivLat = 33 + FRAC_BITS + 2;

  logic [ThrW-1:0] thr_q;
  logic            en;
  logic            out_valid;
  fix_t [2:0]      org, dir, lo, hi;
  logic            p_valid;
  diff_t [2:0]     dlo, dhi;
  fix_t [2:0]      p_dir;
  flags_t          p_flags;
  fix_t [2:0]      qlo, qhi;
  logic [2:0]      vlo, vhi;
  flags_t          fl_q [DivLat];

  // Hold the threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrW'(1);
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // Advance every stage unless a result waits on a stalled receiver
  assign en          = !out_valid || hit_o.ready;
  assign ray_i.ready = en;

  assign org = {ray_i.origin_z, ray_i.origin_y, ray_i.origin_x};
  assign dir = {ray_i.dir_z, ray_i.dir_y, ray_i.dir_x};
  assign lo  = {ray_i.box_min_z, ray_i.box_min_y, ray_i.box_min_x};
  assign hi  = {ray_i.box_max_z, ray_i.box_max_y, ray_i.box_max_x};

  rbsi_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (ray_i.valid),
    .thr_i   (thr_q),
    .org_i   (org),
    .dir_i   (dir),
    .lo_i    (lo),
    .hi_i    (hi),
    .valid_o (p_valid),
    .dlo_o   (dlo),
    .dhi_o   (dhi),
    .dir_o   (p_dir),
    .flags_o (p_flags)
  );

  for (genvar a = 0; a < 3; a++) begin : g_axis
    rbsi_divider #(.FRAC_BITS(FRAC_BITS)) u_div_lo (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (p_valid),
      .num_i   (dlo[a]),
      .den_i   (p_dir[a]),
      .valid_o (vlo[a]),
      .quo_o   (qlo[a])
    );
    rbsi_divider #(.FRAC_BITS(FRAC_BITS)) u_div_hi (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (p_valid),
      .num_i   (dhi[a]),
      .den_i   (p_dir[a]),
      .valid_o (vhi[a]),
      .quo_o   (qhi[a])
    );
  end

  // Delay the axis flags alongside the dividers
  always_ff @(posedge clk_i) begin
    if (en) begin
      fl_q[0] <= p_flags;
      for (int s = 1; s < DivLat; s++) begin
        fl_q[s] <= fl_q[s-1];
      end
    end
  end

  rbsi_combine u_combine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vlo[0] & vhi[0] & vlo[1] & vhi[1] & vlo[2] & vhi[2]),
    .qlo_i   (qlo),
    .qhi_i   (qhi),
    .flags_i (fl_q[DivLat-1]),
    .valid_o (out_valid),
    .hit_o   (hit_o.hit),
    .dist_o  (hit_o.entry_distance)
  );

  assign hit_o.valid = out_valid;

endmodule
`default_nettype wire

[tb/ray_box_slab_intersect_test.sv]
// Testbench for the ray/box slab intersection block: directed and random items.
`timescale 1ns / 1ps
module ray_box_slab_intersect_test;
  import rbsi_pkg::*;

  localparam int unsigned Latency = 56;

  typedef struct {
    logic signed [31:0] org [3];
    logic signed [31:0] dir [3];
    logic signed [31:0] bmin [3];
    logic signed [31:0] bmax [3];
  } ray_item_t;

  typedef struct {
    logic        hit;
    logic [30:0] entry;
  } hit_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [ThrW-1:0] cfg_wdata_i = '0;

  rbsi_ray_if ray_bus ();
  rbsi_hit_if hit_bus ();

  ray_box_slab_intersect i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .ray_i       (ray_bus.sink),
    .hit_o       (hit_bus.source)
  );

  always #10 clk_i = ~clk_i;

  logic [ThrW-1:0] threshold = 16'd1;
  hit_item_t expected_hits [$];
  int unsigned mismatches = 0;
  int unsigned hold_off = 0;
  bit random_stall = 1'b1;

  // Saturate a 64-bit quotient to the signed 32-bit range.
  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Run the three-axis slab test on one item.
  function automatic hit_item_t slab_predict(ray_item_t r);
    hit_item_t res;
    longint lower, upper, o, d, lo, hi, mag, a, b, t;
    bit ok;
    lower = 0;
    upper = 64'sd2147483647;
    ok = 1'b1;
    for (int ax = 0; ax < 3 && ok; ax++) begin
      o = r.org[ax];
      d = r.dir[ax];
      lo = r.bmin[ax];
      hi = r.bmax[ax];
      mag = d < 0 ? -d : d;
      if (mag <= longint'(threshold)) begin
        ok = !(o < lo || o > hi);
      end else begin
        a = clamp32(((lo - o) * 65536) / d);
        b = clamp32(((hi - o) * 65536) / d);
        if (a > b) begin
          t = a; a = b; b = t;
        end
        if (a > lower) lower = a;
        if (b < upper) upper = b;
        ok = lower <= upper;
      end
    end
    res.hit = ok;
    res.entry = ok ? lower[30:0] : '0;
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    mismatches++;
  endtask

  // Random gap: mostly short, sometimes long.
  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Send one item, record its expected result.
  task automatic send_ray(ray_item_t r);
    int unsigned gap;
    gap = random_stall ? pick_gap() : 0;
    if (gap != 0) begin
      ray_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    ray_bus.valid <= 1'b1;
    ray_bus.origin_x <= r.org[0]; ray_bus.origin_y <= r.org[1];
    ray_bus.origin_z <= r.org[2];
    ray_bus.dir_x <= r.dir[0]; ray_bus.dir_y <= r.dir[1]; ray_bus.dir_z <= r.dir[2];
    ray_bus.box_min_x <= r.bmin[0]; ray_bus.box_min_y <= r.bmin[1];
    ray_bus.box_min_z <= r.bmin[2];
    ray_bus.box_max_x <= r.bmax[0]; ray_bus.box_max_y <= r.bmax[1];
    ray_bus.box_max_z <= r.bmax[2];
    do @(posedge clk_i); while (!ray_bus.ready);
    expected_hits.push_back(slab_predict(r));
  endtask

  // Stop offering items and wait until every expected item has come out.
  task automatic drain();
    int unsigned n;
    n = 0;
    ray_bus.valid <= 1'b0;
    while (expected_hits.size() != 0) begin
      @(posedge clk_i);
      n++;
    end
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [ThrW-1:0] v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    threshold = v;
    @(posedge clk_i);
  endtask

  // Random coordinate: mostly small, sometimes full range.
  function automatic logic signed [31:0] rand_coord();
    int unsigned p;
    p = $urandom_range(0, 9);
    if (p < 6) return $signed($urandom_range(0, 32'h00C8_0000)) - 32'sh0064_0000;
    if (p < 8) return $signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
    return $urandom;
  endfunction

  function automatic ray_item_t rand_ray();
    ray_item_t r;
    logic signed [31:0] x, y;
    for (int ax = 0; ax < 3; ax++) begin
      r.org[ax] = rand_coord();
      r.dir[ax] = rand_coord();
      if ($urandom_range(0, 9) == 0) r.dir[ax] = $signed($urandom_range(0, 6)) - 3;
      x = rand_coord();
      y = rand_coord();
      // Mostly well-formed boxes, some inverted.
      if ($urandom_range(0, 9) != 0 && x > y) begin
        r.bmin[ax] = y; r.bmax[ax] = x;
      end else begin
        r.bmin[ax] = x; r.bmax[ax] = y;
      end
    end
    return r;
  endfunction

  function automatic ray_item_t make_ray(logic signed [31:0] o, logic signed [31:0] d,
                                         logic signed [31:0] lo, logic signed [31:0] hi);
    ray_item_t r;
    for (int ax = 0; ax < 3; ax++) begin
      r.org[ax] = o; r.dir[ax] = d; r.bmin[ax] = lo; r.bmax[ax] = hi;
    end
    return r;
  endfunction

  // Directed: field extremes, parallel axes, touching, inverted, saturation.
  task automatic test_directed();
    ray_item_t r;
    send_ray(make_ray(0, 32'sh0001_0000, -32'sh0001_0000, 32'sh0001_0000));
    send_ray(make_ray(-32'sh0005_0000, 32'sh0001_0000, 0, 32'sh0001_0000));
    send_ray(make_ray(32'sh0005_0000, 32'sh0001_0000, 0, 32'sh0001_0000));
    send_ray(make_ray(0, 0, 0, 0));
    send_ray(make_ray(0, 1, 1, 2));
    send_ray(make_ray(0, -1, -1, 0));
    send_ray(make_ray(0, 2, -5, 5));
    send_ray(make_ray(TMin, 1, TMin, TMax));
    send_ray(make_ray(TMin, 2, TMax, TMax));
    send_ray(make_ray(TMax, TMin, TMin, TMax));
    send_ray(make_ray(TMin, TMax, TMin, TMax));
    send_ray(make_ray(TMax, TMax, TMin, TMin));
    send_ray(make_ray(0, 32'sh0001_0000, 32'sh0001_0000, -32'sh0001_0000));
    send_ray(make_ray(0, 0, 32'sh0001_0000, -32'sh0001_0000));
    send_ray(make_ray(-1, 32'hFFFF_FFFF, 32'sh7FFF_0000, 32'sh7FFF_FFFF));
    send_ray(make_ray(-32'sh0000_0003, 3, 32'sh7000_0000, TMax));
    r = make_ray(0, 32'sh0001_0000, 0, 32'sh0001_0000);
    r.dir[1] = 0; r.org[1] = 32'sh0002_0000;
    send_ray(r);
    r.org[1] = 32'sh0001_0000;
    send_ray(r);
    r.dir[2] = -32'sh0000_8000; r.org[2] = 32'sh0004_0000;
    send_ray(r);
  endtask

  task automatic test_random(int unsigned count);
    repeat (count) send_ray(rand_ray());
  endtask

  // Hold the receiver off long enough to fill the pipeline.
  task automatic test_backpressure();
    drain();
    hold_off = 200;
    test_random(120);
    drain();
  endtask

  // Check each result item against the oldest expectation.
  always @(posedge clk_i) begin
    if (hit_bus.valid && hit_bus.ready) begin
      if (expected_hits.size() == 0) begin
        report_mismatch("unexpected item", 1, 0);
      end else begin
        if (hit_bus.hit !== expected_hits[0].hit)
          report_mismatch("hit", hit_bus.hit, expected_hits[0].hit);
        if (hit_bus.entry_distance !== expected_hits[0].entry)
          report_mismatch("entry_distance", hit_bus.entry_distance,
                          expected_hits[0].entry);
        void'(expected_hits.pop_front());
      end
    end
  end

  // Drive ready: long hold-off when asked, else random stalls, or always ready.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hit_bus.ready <= 1'b0;
    end else if (hold_off != 0) begin
      hold_off <= hold_off - 1;
      hit_bus.ready <= 1'b0;
    end else if (random_stall) begin
      hit_bus.ready <= ($urandom_range(0, 99) < 70) ||
                       ($urandom_range(0, 99) < 50);
    end else begin
      hit_bus.ready <= 1'b1;
    end
  end

  initial begin
    ray_bus.valid = 1'b0;
    ray_bus.origin_x = '0; ray_bus.origin_y = '0; ray_bus.origin_z = '0;
    ray_bus.dir_x = '0; ray_bus.dir_y = '0; ray_bus.dir_z = '0;
    ray_bus.box_min_x = '0; ray_bus.box_min_y = '0; ray_bus.box_min_z = '0;
    ray_bus.box_max_x = '0; ray_bus.box_max_y = '0; ray_bus.box_max_z = '0;
    hit_bus.ready = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(150);
    write_threshold(16'd0);
    test_directed();
    test_random(80);
    write_threshold(16'hFFFF);
    test_directed();
    test_random(80);
    write_threshold(16'h0100);
    test_backpressure();
    random_stall = 1'b0;
    test_random(60);
    random_stall = 1'b1;
    write_threshold(16'd1);
    test_random(100);
    drain();
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end

endmodule

[files.f]
rtl/rbsi_pkg.sv
rtl/rbsi_if.sv
rtl/rbsi_prep.sv
rtl/rbsi_divider.sv
rtl/rbsi_combine.sv
rtl/ray_box_slab_intersect.sv
tb/ray_box_slab_intersect_test.sv
